FILE: hw/rtl/uniform_sphere_surface_sampler_top_defines.svh
// Assertion macros for the uniform sphere surface sampler.
// Included by the RTL files that carry assertions; no other dependencies.
`ifndef UNIFORM_SPHERE_SURFACE_SAMPLER_TOP_DEFINES_SVH
`define UNIFORM_SPHERE_SURFACE_SAMPLER_TOP_DEFINES_SVH
`ifndef SYNTH
`define USSP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define USSP_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition");
`else
`define USSP_ASSERT(lbl, clk, rstn, prop)
`define USSP_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

FILE: hw/rtl/ussp_pkg.sv
// Types, constants and helpers of the uniform sphere surface sampler.
// No dependencies; imported by every RTL module of the block.
`default_nettype none
package ussp_pkg;

  localparam int CORDIC_STEPS    = 17;
  localparam int ISQRT_STEPS     = 16;
  localparam int STEPS_PER_STAGE = 3;
  localparam int STAGES          = 6;
  localparam int DIV_BITS        = 64;

  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  localparam logic [63:0] PDF_NUM   = 64'd22399066950089;
  localparam logic [31:0] PDF_RESET = 32'd5215;
  localparam logic [31:0] RADIUS_RESET = 32'd65536;

  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_CENTER_Z = 2'd2;
  localparam logic [1:0] REG_RADIUS   = 2'd3;

  typedef enum logic [2:0] {
    PDF_IDLE,
    PDF_SQR,
    PDF_PREP,
    PDF_DIV,
    PDF_DONE
  } pdf_state_t;

  typedef struct packed {
    logic [15:0] sample_u;
    logic [15:0] sample_v;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [31:0]        area_pdf;
  } out_word_t;

  typedef struct packed {
    logic               valid;
    logic [1:0]         q;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] t;
    logic [31:0]        n;
    logic [31:0]        res;
    logic signed [15:0] nz;
  } stage_t;

  function automatic logic signed [33:0] atan_turn(input int idx);
    case (idx)
      0:  return 34'sd536870912;
      1:  return 34'sd316933406;
      2:  return 34'sd167458905;
      3:  return 34'sd85004755;
      4:  return 34'sd42667331;
      5:  return 34'sd21354465;
      6:  return 34'sd10679838;
      7:  return 34'sd5340245;
      8:  return 34'sd2670163;
      9:  return 34'sd1335087;
      10: return 34'sd667544;
      11: return 34'sd333772;
      12: return 34'sd166886;
      13: return 34'sd83443;
      14: return 34'sd41722;
      15: return 34'sd20861;
      16: return 34'sd10430;
      default: return 34'sd0;
    endcase
  endfunction

  function automatic logic signed [15:0] sat_s16(input logic signed [49:0] v);
    if (v > 50'sd32767) begin
      return 16'sh7fff;
    end else if (v < -50'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [31:0] sat_s32(input logic signed [48:0] v);
    if (v > 49'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -49'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ussp_stage.sv
// One pipeline stage: up to three CORDIC rotations and up to three square-root iterations.
// Depends on ussp_pkg.
`default_nettype none
module ussp_stage #(
  parameter int BASE = 0
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire ussp_pkg::stage_t d,
  output ussp_pkg::stage_t      q
);
  import ussp_pkg::*;

  stage_t s_nxt;
  stage_t q_r;

  always_comb begin
    s_nxt = d;
    for (int j = 0; j < STEPS_PER_STAGE; j++) begin : g_step
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic [31:0]        bitv;
      logic [31:0]        trial;
      dx    = s_nxt.y >>> (BASE + j);
      dy    = s_nxt.x >>> (BASE + j);
      bitv  = 32'd1 << (30 - 2 * (BASE + j));
      trial = s_nxt.res + bitv;
      if (BASE + j < CORDIC_STEPS) begin
        if (!s_nxt.t[33]) begin
          s_nxt.x = s_nxt.x - dx;
          s_nxt.y = s_nxt.y + dy;
          s_nxt.t = s_nxt.t - atan_turn(BASE + j);
        end else begin
          s_nxt.x = s_nxt.x + dx;
          s_nxt.y = s_nxt.y - dy;
          s_nxt.t = s_nxt.t + atan_turn(BASE + j);
        end
      end
      if (BASE + j < ISQRT_STEPS) begin
        if (s_nxt.n >= trial) begin
          s_nxt.n   = s_nxt.n - trial;
          s_nxt.res = (s_nxt.res >> 1) + bitv;
        end else begin
          s_nxt.res = s_nxt.res >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else begin
      q_r <= s_nxt;
    end
  end

  assign q = q_r;

endmodule
`default_nettype wire

FILE: hw/rtl/ussp_scale.sv
// Back end: quadrant fold, normal rounding, radius scaling, center offset.
// Depends on ussp_pkg.
`default_nettype none
module ussp_scale (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ussp_pkg::stage_t d,
  input  wire logic [31:0]      center_x,
  input  wire logic [31:0]      center_y,
  input  wire logic [31:0]      center_z,
  input  wire logic [31:0]      radius,
  input  wire logic [31:0]      pdf,
  output logic                  out_valid,
  output ussp_pkg::out_word_t   out_data
);
  import ussp_pkg::*;

  logic [14:0]        rho;
  logic signed [33:0] c;
  logic signed [33:0] s;
  logic signed [49:0] pc_nxt;
  logic signed [49:0] ps_nxt;

  logic               a_valid_r;
  logic signed [49:0] pc_r;
  logic signed [49:0] ps_r;
  logic signed [15:0] nz_a_r;

  logic signed [15:0] nx_nxt;
  logic signed [15:0] ny_nxt;
  logic signed [32:0] rad_s;

  logic               b_valid_r;
  logic signed [15:0] nx_r;
  logic signed [15:0] ny_r;
  logic signed [15:0] nz_r;
  logic signed [48:0] mx_r;
  logic signed [48:0] my_r;
  logic signed [48:0] mz_r;

  logic signed [48:0] px;
  logic signed [48:0] py;
  logic signed [48:0] pz;

  logic      out_valid_r;
  out_word_t out_data_r;

  always_comb begin
    rho = (d.res > 32'd32767) ? 15'h7fff : d.res[14:0];
    case (d.q)
      2'd0: begin
        c = d.x;
        s = d.y;
      end
      2'd1: begin
        c = -d.y;
        s = d.x;
      end
      2'd2: begin
        c = -d.x;
        s = -d.y;
      end
      default: begin
        c = d.y;
        s = -d.x;
      end
    endcase
    pc_nxt = $signed({1'b0, rho}) * c;
    ps_nxt = $signed({1'b0, rho}) * s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= d.valid;
    end
    pc_r   <= pc_nxt;
    ps_r   <= ps_nxt;
    nz_a_r <= d.nz;
  end

  assign nx_nxt = sat_s16((pc_r + 50'sd536870912) >>> 30);
  assign ny_nxt = sat_s16((ps_r + 50'sd536870912) >>> 30);
  assign rad_s  = $signed({1'b0, radius});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
    nx_r <= nx_nxt;
    ny_r <= ny_nxt;
    nz_r <= nz_a_r;
    mx_r <= rad_s * nx_nxt;
    my_r <= rad_s * ny_nxt;
    mz_r <= rad_s * nz_a_r;
  end

  assign px = 49'($signed(center_x)) + ((mx_r + 49'sd16384) >>> 15);
  assign py = 49'($signed(center_y)) + ((my_r + 49'sd16384) >>> 15);
  assign pz = 49'($signed(center_z)) + ((mz_r + 49'sd16384) >>> 15);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= b_valid_r;
    end
    out_data_r.point_x  <= sat_s32(px);
    out_data_r.point_y  <= sat_s32(py);
    out_data_r.point_z  <= sat_s32(pz);
    out_data_r.normal_x <= nx_r;
    out_data_r.normal_y <= ny_r;
    out_data_r.normal_z <= nz_r;
    out_data_r.area_pdf <= pdf;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

FILE: hw/rtl/ussp_pdf_div.sv
// Area density unit: squares the radius and divides one bit per cycle.
// Depends on ussp_pkg.
`default_nettype none
module ussp_pdf_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        go,
  input  wire logic [31:0] radius,
  output logic             busy,
  output logic [31:0]      pdf
);
  import ussp_pkg::*;

  pdf_state_t state_r;
  pdf_state_t state_nxt;

  logic [63:0] sq_r;
  logic [63:0] num_r;
  logic [63:0] rem_r;
  logic [63:0] quo_r;
  logic [5:0]  cnt_r;
  logic [31:0] pdf_r;
  logic [64:0] rem_t;
  logic        take;
  logic        load;
  logic        step;
  logic        finish;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      PDF_IDLE: state_nxt = PDF_IDLE;
      PDF_SQR:  state_nxt = PDF_PREP;
      PDF_PREP: state_nxt = PDF_DIV;
      PDF_DIV:  state_nxt = (cnt_r == 6'd0) ? PDF_DONE : PDF_DIV;
      PDF_DONE: state_nxt = PDF_IDLE;
      default:  state_nxt = PDF_IDLE;
    endcase
    if (go) begin
      state_nxt = PDF_SQR;
    end
  end

  always_comb begin
    busy   = (state_r != PDF_IDLE);
    load   = (state_r == PDF_PREP);
    step   = (state_r == PDF_DIV);
    finish = (state_r == PDF_DONE);
  end

  assign rem_t = {rem_r, num_r[63]};
  assign take  = (rem_t >= {1'b0, sq_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PDF_IDLE;
      pdf_r   <= PDF_RESET;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        if (radius == 32'd0 || quo_r[63:32] != 32'd0) begin
          pdf_r <= 32'hffffffff;
        end else begin
          pdf_r <= quo_r[31:0];
        end
      end
    end
    sq_r <= radius * radius;
    if (load) begin
      num_r <= PDF_NUM + (sq_r >> 1);
      rem_r <= 64'd0;
      quo_r <= 64'd0;
      cnt_r <= 6'(DIV_BITS - 1);
    end else if (step) begin
      num_r <= num_r << 1;
      rem_r <= take ? 64'(rem_t - {1'b0, sq_r}) : rem_t[63:0];
      quo_r <= {quo_r[62:0], take};
      cnt_r <= cnt_r - 6'd1;
    end
  end

  assign pdf = pdf_r;

endmodule
`default_nettype wire

FILE: hw/rtl/uniform_sphere_surface_sampler_top.sv
// Uniform sphere surface sampler: an item may enter on every cycle while busy
// is low, and its result word appears on out_valid/out_data after passing the
// input register, six CORDIC/square-root stages and three scaling stages.
// The receiver cannot stall. Writing sphere_radius raises busy while the
// area density is squared and divided.
// Depends on ussp_pkg, ussp_stage, ussp_scale, ussp_pdf_div and the defines header.
`default_nettype none
`include "uniform_sphere_surface_sampler_top_defines.svh"
module uniform_sphere_surface_sampler_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire ussp_pkg::in_word_t in_data,
  output logic                    out_valid,
  output ussp_pkg::out_word_t     out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import ussp_pkg::*;

  localparam int PIPE_LAT = 10;

  logic [31:0] center_x_r;
  logic [31:0] center_y_r;
  logic [31:0] center_z_r;
  logic [31:0] radius_r;
  logic        cfg_wr;
  logic        accept;
  logic [31:0] pdf;

  logic        v0_r;
  logic [15:0] u_r;
  logic [15:0] v_r;
  logic [16:0] u_sum;
  logic [1:0]  quad;
  logic [15:0] r16;
  logic signed [15:0] nz;
  logic [31:0] nz_sq;

  stage_t chain [0:STAGES];

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= 32'd0;
      center_y_r <= 32'd0;
      center_z_r <= 32'd0;
      radius_r   <= RADIUS_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_CENTER_X: center_x_r <= pwdata;
        REG_CENTER_Y: center_y_r <= pwdata;
        REG_CENTER_Z: center_z_r <= pwdata;
        REG_RADIUS:   radius_r   <= pwdata;
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CENTER_X: prdata = center_x_r;
      REG_CENTER_Y: prdata = center_y_r;
      REG_CENTER_Z: prdata = center_z_r;
      REG_RADIUS:   prdata = radius_r;
      default:      prdata = 32'd0;
    endcase
  end

  ussp_pdf_div u_pdf (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (cfg_wr && paddr[3:2] == REG_RADIUS),
    .radius (radius_r),
    .busy   (busy),
    .pdf    (pdf)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= accept;
    end
    if (accept) begin
      u_r <= in_data.sample_u;
      v_r <= in_data.sample_v;
    end
  end

  assign u_sum = {1'b0, u_r} + 17'h04000;
  assign quad  = u_sum[15:14];
  assign r16   = u_r - {quad, 14'd0};
  assign nz    = $signed({~v_r[15], v_r[14:0]});
  assign nz_sq = 32'(nz * nz);

  always_comb begin
    chain[0].valid = v0_r;
    chain[0].q     = quad;
    chain[0].x     = CORDIC_START;
    chain[0].y     = 34'sd0;
    chain[0].t     = $signed({{2{r16[15]}}, r16, 16'd0});
    chain[0].n     = 32'h40000000 - nz_sq;
    chain[0].res   = 32'd0;
    chain[0].nz    = nz;
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    ussp_stage #(
      .BASE (k * STEPS_PER_STAGE)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .d     (chain[k]),
      .q     (chain[k+1])
    );
  end

  ussp_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .d         (chain[STAGES]),
    .center_x  (center_x_r),
    .center_y  (center_y_r),
    .center_z  (center_z_r),
    .radius    (radius_r),
    .pdf       (pdf),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  `USSP_ASSERT(a_latency, clk, rst_n, start && !busy |-> ##PIPE_LAT out_valid)
  `USSP_ASSERT(a_origin, clk, rst_n, out_valid |-> $past(start && !busy, PIPE_LAT))
  `USSP_ASSERT(a_radius_busy, clk, rst_n, cfg_wr && paddr[3:2] == REG_RADIUS |=> busy)

endmodule
`default_nettype wire

FILE: dv/tb_uniform_sphere_surface_sampler_top.sv
// Self-checking testbench for uniform_sphere_surface_sampler_top: drives sample words,
// predicts each point, normal and area density in fixed point, checks every result.
// Depends on ussp_pkg and the sampler RTL.
`timescale 1ns / 1ps
module tb_uniform_sphere_surface_sampler_top;
  import ussp_pkg::*;

  localparam int LIMIT = 400000;
  localparam longint unsigned PDF_SCALE = 64'd22399066950089;
  localparam longint START_X = 652032874;
  localparam longint ATAN_TAB [17] = '{536870912, 316933406, 167458905, 85004755, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722,
    20861, 10430};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_word_t    in_data = '0;
  logic        out_valid;
  out_word_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [31:0] ctr_x = 0, ctr_y = 0, ctr_z = 0, radius = 32'd65536;
  in_word_t    sample_q[$];
  out_word_t   point_q[$];
  logic        took = 1'b0;
  int          idle_pct = 0;
  int          cycles = 0;
  int          n_errors = 0;
  int          n_words = 0;
  int          n_results = 0;

  uniform_sphere_surface_sampler_top u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] root32(input logic [31:0] n);
    logic [31:0] res;
    logic [31:0] b;
    res = 0;
    b = 32'h4000_0000;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint clampl(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [31:0] place(input logic [31:0] c, input longint n);
    longint off;
    off = (longint'({32'b0, radius}) * n + 16384) >>> 15;
    return 32'(clampl(longint'($signed(c)) + off, -64'sd2147483648, 64'sd2147483647));
  endfunction

  function automatic out_word_t sphere_point(input in_word_t w);
    out_word_t r;
    logic [31:0] q, r16, rho;
    longint nz, ang, x, y, t, dx, dy, c, s, nx, ny;
    longint unsigned sq, pdf;
    nz = longint'(w.sample_v) - 32768;
    rho = root32(32'(64'sd1073741824 - nz * nz));
    if (rho > 32767) rho = 32767;
    q = ((32'(w.sample_u) + 32'h4000) >> 14) & 32'd3;
    r16 = (32'(w.sample_u) - q * 32'h4000) & 32'hFFFF;
    ang = r16[15] ? longint'(r16) - 65536 : longint'(r16);
    x = START_X;
    y = 0;
    t = ang * 65536;
    for (int i = 0; i < 17; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (t >= 0) begin
        x = x - dx; y = y + dy; t = t - ATAN_TAB[i];
      end else begin
        x = x + dx; y = y - dy; t = t + ATAN_TAB[i];
      end
    end
    case (q)
      0: begin c = x; s = y; end
      1: begin c = -y; s = x; end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    nx = clampl((longint'(rho) * c + 536870912) >>> 30, -32768, 32767);
    ny = clampl((longint'(rho) * s + 536870912) >>> 30, -32768, 32767);
    if (radius == 0) begin
      pdf = 64'hFFFF_FFFF;
    end else begin
      sq = longint'({32'b0, radius}) * longint'({32'b0, radius});
      pdf = (PDF_SCALE + sq / 2) / sq;
      if (pdf > 64'hFFFF_FFFF) pdf = 64'hFFFF_FFFF;
    end
    r.point_x = place(ctr_x, nx);
    r.point_y = place(ctr_y, ny);
    r.point_z = place(ctr_z, nz);
    r.normal_x = 16'(nx);
    r.normal_y = 16'(ny);
    r.normal_z = 16'(nz);
    r.area_pdf = 32'(pdf);
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    n_errors++;
    $display("ERROR result %0d %s: got %h want %h", n_results, what, got, want);
  endtask

  always @(posedge clk) begin
    out_word_t e;
    cycles <= cycles + 1;
    took <= start && !busy;
    if (rst_n && start && !busy) begin
      point_q.push_back(sphere_point(in_data));
      n_words++;
    end
    if (rst_n && out_valid) begin
      if (point_q.size() == 0) begin
        report("unexpected word", out_data.area_pdf, 0);
      end else begin
        e = point_q.pop_front();
        if (out_data.point_x !== e.point_x) report("point_x", out_data.point_x, e.point_x);
        if (out_data.point_y !== e.point_y) report("point_y", out_data.point_y, e.point_y);
        if (out_data.point_z !== e.point_z) report("point_z", out_data.point_z, e.point_z);
        if (out_data.normal_x !== e.normal_x)
          report("normal_x", 32'(out_data.normal_x), 32'(e.normal_x));
        if (out_data.normal_y !== e.normal_y)
          report("normal_y", 32'(out_data.normal_y), 32'(e.normal_y));
        if (out_data.normal_z !== e.normal_z)
          report("normal_z", 32'(out_data.normal_z), 32'(e.normal_z));
        if (out_data.area_pdf !== e.area_pdf) report("area_pdf", out_data.area_pdf, e.area_pdf);
      end
      n_results++;
    end
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("uniform_sphere_surface_sampler_top: mismatch");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!start || took)) begin
      if (sample_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        in_data <= sample_q.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    while (busy) @(negedge clk);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      REG_CENTER_X: ctr_x = val;
      REG_CENTER_Y: ctr_y = val;
      REG_CENTER_Z: ctr_z = val;
      default: radius = val;
    endcase
    while (busy) @(negedge clk);
  endtask

  task automatic drain();
    do @(posedge clk); while (sample_q.size() != 0 || start || point_q.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_sphere(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic [31:0] r);
    reg_write(REG_CENTER_X, x);
    reg_write(REG_CENTER_Y, y);
    reg_write(REG_CENTER_Z, z);
    reg_write(REG_RADIUS, r);
  endtask

  initial begin
    logic [15:0] edge_u [8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF,
                                16'h2000, 16'h1FFF, 16'h6000};
    logic [15:0] edge_v [3] = '{16'h0000, 16'hFFFF, 16'h8000};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (edge_u[i]) sample_q.push_back('{edge_u[i], edge_v[i % 3]});
    foreach (edge_v[i]) sample_q.push_back('{16'h1234, edge_v[i]});
    sample_q.push_back('{16'h5555, 16'h0001});
    drain();
    set_sphere(0, 0, 0, 0);
    sample_q.push_back('{16'h0000, 16'h0000});
    sample_q.push_back('{16'hFFFF, 16'hFFFF});
    drain();
    set_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    sample_q.push_back('{16'h0000, 16'hFFFF});
    sample_q.push_back('{16'h8000, 16'h0000});
    drain();
    for (int p = 0; p < 9; p++) begin
      idle_pct = p < 3 ? 10 : (p < 6 ? 86 : 0);
      case (p % 5)
        0: set_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
        1: set_sphere($urandom, $urandom, $urandom, $urandom_range(3));
        2: set_sphere($urandom, $urandom, $urandom, $urandom);
        3: set_sphere($urandom_range(65535), 0, 32'hFFFF_0000, $urandom_range(1 << 20));
        default: set_sphere(0, 0, 0, 32'd65536);
      endcase
      repeat (183) sample_q.push_back('{16'($urandom), 16'($urandom)});
      drain();
    end
    $display("covered %0d sample words and %0d results over 12 sphere settings,",
             n_words, n_results);
    $display("including zero and tiny radii and saturating centers");
    if (n_errors == 0) begin
      $display("uniform_sphere_surface_sampler_top: match");
    end else begin
      $display("uniform_sphere_surface_sampler_top: mismatch");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/ussp_pkg.sv
hw/rtl/ussp_stage.sv
hw/rtl/ussp_scale.sv
hw/rtl/ussp_pdf_div.sv
hw/rtl/uniform_sphere_surface_sampler_top.sv
dv/tb_uniform_sphere_surface_sampler_top.sv
